[rtl/core/pixel_width_word_wrapper_assert.svh]
// Assertion macros shared by the word wrapper RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef PIXEL_WIDTH_WORD_WRAPPER_ASSERT_SVH
`define PIXEL_WIDTH_WORD_WRAPPER_ASSERT_SVH
`ifndef ASSERT_OFF
// Condition holds at every edge out of reset.
`define PWW_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Consequent holds in the same cycle.
`define PWW_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Consequent holds in the following cycle.
`define PWW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PWW_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define PWW_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define PWW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/pww_pkg.sv]
// Package for the pixel width word wrapper: widths, character codes,
// command and status structs. No dependencies.
package pww_pkg;

	localparam int LINE_CHARS_DEF = 63;
	localparam int CHAR_W         = 21;
	localparam int ADV_W          = 16;
	localparam int FRAC_BITS      = 6;
	localparam int ADVP_W         = ADV_W - FRAC_BITS;
	localparam int PIX_W          = 17;
	localparam int WIDTH_W        = 16;
	localparam int PTR_W          = 6;
	localparam int QUEUE_DEPTH    = 2;
	localparam int OUT_DEPTH      = 2;

	localparam logic [CHAR_W-1:0]  CH_NEWLINE     = 21'd10;
	localparam logic [CHAR_W-1:0]  CH_SPACE       = 21'd32;
	localparam logic [PIX_W-1:0]   PIX_MAX        = 17'h1FFFF;
	localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST = 16'd640;

	localparam logic MODE_CHAR  = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	// One line to emit: ring start, stored characters, trailing newline.
	typedef struct packed {
		logic [PTR_W-1:0] start;
		logic [PTR_W-1:0] len;
		logic             nl;
	} cmd_t;

	// Emitter progress, seen by the front to protect unread ring entries.
	typedef struct packed {
		logic             busy;
		logic [PTR_W-1:0] addr;
	} back_stat_t;

endpackage

[rtl/core/pww_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module pww_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/pww_cmd_queue.sv]
// Short FIFO of line commands between the classifier and the emitter.
// Depends on pww_pkg.
module pww_cmd_queue #(
	parameter int DEPTH = pww_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pww_pkg::cmd_t push_cmd,
	input  logic          pop,
	output pww_pkg::cmd_t front,
	output logic          empty,
	output logic          full
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	pww_pkg::cmd_t ent_q [DEPTH];
	logic [IW-1:0] rd_ptr_q;
	logic [IW-1:0] wr_ptr_q;
	logic [NW-1:0] cnt_q;

	assign front = ent_q[rd_ptr_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == NW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + NW'(push) - NW'(pop);
		end
	end

endmodule

[rtl/core/pww_front.sv]
// Front end: accept words, track line state, store characters in the ring
// and queue line commands. Depends on pww_pkg and the assertion header.
`include "pixel_width_word_wrapper_assert.svh"
module pww_front #(
	parameter int LINE_CHARS = pww_pkg::LINE_CHARS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic [pww_pkg::CHAR_W-1:0]          char_code,
	input  logic [pww_pkg::ADV_W-1:0]           advance_fixed,
	input  logic [pww_pkg::WIDTH_W-1:0]         line_width,
	input  logic                                q_full,
	input  logic                                q_empty,
	input  pww_pkg::cmd_t                       q_front,
	input  pww_pkg::back_stat_t                 back_stat,
	output logic                                push,
	output pww_pkg::cmd_t                       push_cmd,
	output logic                                ram_we,
	output logic [$clog2(LINE_CHARS+1)-1:0]     ram_waddr,
	output logic [pww_pkg::CHAR_W-1:0]          ram_wdata
);

	localparam int CW   = $clog2(LINE_CHARS + 1);
	localparam int RING = 2 ** CW;
	localparam int PW   = pww_pkg::PIX_W;

	logic [CW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] pix_q;
	logic [CW-1:0] we_idx_q;
	logic [PW-1:0] we_pix_q;
	logic          we_valid_q;

	logic [CW-1:0] n_head;
	logic [CW-1:0] n_count;
	logic [PW-1:0] n_pix;
	logic [CW-1:0] n_we_idx;
	logic [PW-1:0] n_we_pix;
	logic          n_we_valid;

	logic [pww_pkg::ADVP_W-1:0] adv;
	logic [CW-1:0]              pend_lo;
	logic [CW-1:0]              unread;
	logic [CW:0]                occ;
	logic                       accept;
	logic                       is_nl;
	logic                       is_sp;
	logic [PW:0]                sum_pa;
	logic                       brk;
	logic [CW:0]                kf;
	logic [CW-1:0]              kf_c;
	logic [PW-1:0]              pix_sub;

	function automatic logic [PW-1:0] sat_add(logic [PW-1:0] a,
			logic [pww_pkg::ADVP_W-1:0] b);
		logic [PW:0] s;
		s = {1'b0, a} + (PW+1)'(b);
		return s[PW] ? pww_pkg::PIX_MAX : s[PW-1:0];
	endfunction

	assign adv = advance_fixed[pww_pkg::ADV_W-1:pww_pkg::FRAC_BITS];

	// Oldest ring entry the emitter has not yet read.
	assign pend_lo = back_stat.busy ? back_stat.addr[CW-1:0] :
	                 (!q_empty ? q_front.start[CW-1:0] : head_q);
	assign unread = head_q - pend_lo;
	assign occ    = {1'b0, unread} + {1'b0, count_q};

	// Hold when the queue is full or the ring could overrun unread entries.
	assign in_stall = q_full || ((occ >= (CW+1)'(RING - 1)) && (unread != '0));
	assign accept   = in_valid && !in_stall;

	assign is_nl  = (char_code == pww_pkg::CH_NEWLINE);
	assign is_sp  = (char_code == pww_pkg::CH_SPACE);
	assign sum_pa = {1'b0, pix_q} + (PW+1)'(adv);
	assign brk    = is_nl || (count_q >= CW'(LINE_CHARS)) ||
	                ((count_q != '0) && (sum_pa > (PW+1)'(line_width)));

	// Keep the characters after the recorded space; drop the space itself.
	assign kf      = (CW+1)'(we_idx_q) + (CW+1)'(2);
	assign kf_c    = (kf > {1'b0, count_q}) ? count_q : kf[CW-1:0];
	assign pix_sub = (pix_q > we_pix_q) ? pix_q - we_pix_q : '0;

	assign ram_wdata = char_code;

	always_comb begin
		n_head     = head_q;
		n_count    = count_q;
		n_pix      = pix_q;
		n_we_idx   = we_idx_q;
		n_we_pix   = we_pix_q;
		n_we_valid = we_valid_q;
		push       = 1'b0;
		push_cmd   = '{start: pww_pkg::PTR_W'(head_q), len: pww_pkg::PTR_W'(count_q),
		               nl: 1'b1};
		ram_we     = 1'b0;
		ram_waddr  = head_q + count_q;
		if (accept) begin
			if (mode == pww_pkg::MODE_FLUSH) begin
				if (count_q != '0) begin
					push         = 1'b1;
					push_cmd.nl  = 1'b0;
					n_head       = head_q + count_q;
					n_count      = '0;
					n_pix        = '0;
					n_we_idx     = '0;
					n_we_pix     = '0;
					n_we_valid   = 1'b0;
				end
			end else begin
				if (brk) begin
					push = 1'b1;
					if (is_nl || !we_valid_q) begin
						n_head  = head_q + count_q;
						n_count = '0;
						n_pix   = '0;
					end else begin
						push_cmd.len = pww_pkg::PTR_W'(we_idx_q + 1'b1);
						n_head       = head_q + kf_c;
						n_count      = count_q - kf_c;
						n_pix        = pix_sub;
					end
					n_we_idx   = '0;
					n_we_pix   = '0;
					n_we_valid = 1'b0;
				end
				if (is_sp && (n_count != '0)) begin
					n_we_idx   = n_count - 1'b1;
					n_we_pix   = sat_add(n_pix, adv);
					n_we_valid = 1'b1;
				end
				if (!is_nl && !((n_count == '0) && is_sp) && (n_count < CW'(LINE_CHARS))) begin
					ram_we    = 1'b1;
					ram_waddr = n_head + n_count;
					n_count   = n_count + 1'b1;
					n_pix     = sat_add(n_pix, adv);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			pix_q      <= '0;
			we_idx_q   <= '0;
			we_pix_q   <= '0;
			we_valid_q <= 1'b0;
		end else begin
			head_q     <= n_head;
			count_q    <= n_count;
			pix_q      <= n_pix;
			we_idx_q   <= n_we_idx;
			we_pix_q   <= n_we_pix;
			we_valid_q <= n_we_valid;
		end
	end

	`PWW_ASSERT_ALWAYS(a_count_cap, clk, arst_n, count_q <= CW'(LINE_CHARS), "line count over capacity")
	`PWW_ASSERT_ALWAYS(a_ring_occ, clk, arst_n, occ <= (CW+1)'(RING), "ring overrun")
	`PWW_ASSERT_IMPLIES(a_word_end, clk, arst_n, we_valid_q, we_idx_q < count_q, "word end past line")
	`PWW_ASSERT_IMPLIES(a_push_room, clk, arst_n, push, !q_full, "push into full queue")

endmodule

[rtl/core/pww_back.sv]
// Back end: pop line commands, read the ring and stream out words through
// a small output buffer. Depends on pww_pkg and the assertion header.
`include "pixel_width_word_wrapper_assert.svh"
module pww_back #(
	parameter int LINE_CHARS = pww_pkg::LINE_CHARS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_empty,
	input  pww_pkg::cmd_t                   q_front,
	output logic                            q_pop,
	output logic                            ram_re,
	output logic [$clog2(LINE_CHARS+1)-1:0] ram_raddr,
	input  logic [pww_pkg::CHAR_W-1:0]      ram_rdata,
	output pww_pkg::back_stat_t             back_stat,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [pww_pkg::CHAR_W-1:0]      out_char,
	output logic                            last_of_line
);

	localparam int CW    = $clog2(LINE_CHARS + 1);
	localparam int OD    = pww_pkg::OUT_DEPTH;
	localparam int OB_IW = (OD > 1) ? $clog2(OD) : 1;
	localparam int OB_CW = $clog2(OD + 1);

	logic          busy_q;
	logic [CW-1:0] addr_q;
	logic [CW-1:0] rem_q;
	logic          nl_q;

	logic fl_valid_s1;
	logic fl_nl_s1;
	logic fl_last_s1;

	logic [pww_pkg::CHAR_W-1:0] buf_char_q [OD];
	logic                       buf_last_q [OD];
	logic [OB_IW-1:0]           buf_rd_q;
	logic [OB_IW-1:0]           buf_wr_q;
	logic [OB_CW-1:0]           buf_cnt_q;

	logic            pop_out;
	logic [OB_CW:0]  level;
	logic [OB_CW:0]  avail;
	logic            issue;
	logic            iss_last;

	assign out_valid    = (buf_cnt_q != '0);
	assign out_char     = buf_char_q[buf_rd_q];
	assign last_of_line = buf_last_q[buf_rd_q];
	assign pop_out      = out_valid && !out_stall;

	// Count buffered plus in-flight words; issue only when a slot is sure.
	assign level = (OB_CW+1)'(buf_cnt_q) + (OB_CW+1)'(fl_valid_s1);
	assign avail = level - (OB_CW+1)'(pop_out);
	assign issue = busy_q && (avail < (OB_CW+1)'(OD));

	assign iss_last  = (rem_q == '0) || ((rem_q == CW'(1)) && !nl_q);
	assign ram_re    = issue && (rem_q != '0);
	assign ram_raddr = addr_q;
	assign q_pop     = !busy_q && !q_empty;

	assign back_stat = '{busy: busy_q, addr: pww_pkg::PTR_W'(addr_q)};

	always_ff @(posedge clk) begin
		if (fl_valid_s1) begin
			buf_char_q[buf_wr_q] <= fl_nl_s1 ? pww_pkg::CH_NEWLINE : ram_rdata;
			buf_last_q[buf_wr_q] <= fl_last_s1;
		end
		if (issue) begin
			fl_nl_s1   <= (rem_q == '0);
			fl_last_s1 <= iss_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			addr_q      <= '0;
			rem_q       <= '0;
			nl_q        <= 1'b0;
			fl_valid_s1 <= 1'b0;
			buf_rd_q    <= '0;
			buf_wr_q    <= '0;
			buf_cnt_q   <= '0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				addr_q <= q_front.start[CW-1:0];
				rem_q  <= q_front.len[CW-1:0];
				nl_q   <= q_front.nl;
			end else if (issue) begin
				if (rem_q != '0) begin
					addr_q <= addr_q + 1'b1;
					rem_q  <= rem_q - 1'b1;
				end
				if (iss_last) begin
					busy_q <= 1'b0;
				end
			end
			fl_valid_s1 <= issue;
			if (fl_valid_s1) begin
				buf_wr_q <= (buf_wr_q == OB_IW'(OD - 1)) ? '0 : buf_wr_q + 1'b1;
			end
			if (pop_out) begin
				buf_rd_q <= (buf_rd_q == OB_IW'(OD - 1)) ? '0 : buf_rd_q + 1'b1;
			end
			buf_cnt_q <= buf_cnt_q + OB_CW'(fl_valid_s1) - OB_CW'(pop_out);
		end
	end

	`PWW_ASSERT_ALWAYS(a_buf_cap, clk, arst_n, level <= (OB_CW+1)'(OD), "output buffer overrun")
	`PWW_ASSERT_IMPLIES(a_pop_idle, clk, arst_n, q_pop, !busy_q, "command popped while busy")
	`PWW_ASSERT_NEXT(a_last_done, clk, arst_n, issue && iss_last, !busy_q, "busy after last word")

endmodule

[rtl/core/pixel_width_word_wrapper.sv]
// Top level of the pixel width greedy word wrapper.
// Depends on pww_pkg, pww_front, pww_cmd_queue, pww_back and pww_ram.
//
// Usage: character words enter on in_valid/in_stall with mode, char_code
// and advance_fixed (10.6 pixels, fraction dropped). Mode 1 flushes the line.
// Lines leave on out_valid/out_stall, one character per word, last_of_line
// set on the final word (the newline, or the last character of a flush).
// line_width is written on cfg_valid/cfg_ready; cfg_ready is always high.
//
// Throughput: one input word per cycle while the command queue has room and
// the character ring is not blocked by a line still being read out. The
// emitter sends one word per cycle once running, while the output buffer has
// room: it first loads the command, then sends one word per stored character
// and the newline (a flush line has no newline).
//
// Reset clears line state, queue and output buffer; line_width returns to
// 640. The ring RAM is not cleared, only written entries are read. When the
// receiver stalls, output words back up into a two-word buffer, then the
// emitter, then the queue, and finally in_stall rises.
module pixel_width_word_wrapper #(
	parameter int LINE_CHARS = pww_pkg::LINE_CHARS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [pww_pkg::CHAR_W-1:0]  char_code,
	input  logic [pww_pkg::ADV_W-1:0]   advance_fixed,
	// output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pww_pkg::CHAR_W-1:0]  out_char,
	output logic                        last_of_line,
	// configuration channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pww_pkg::WIDTH_W-1:0] line_width
);

	localparam int CW   = $clog2(LINE_CHARS + 1);
	localparam int RING = 2 ** CW;

	logic [pww_pkg::WIDTH_W-1:0] line_width_q;

	logic                       push;
	pww_pkg::cmd_t              push_cmd;
	logic                       q_pop;
	pww_pkg::cmd_t              q_front;
	logic                       q_empty;
	logic                       q_full;
	pww_pkg::back_stat_t        back_stat;
	logic                       ram_we;
	logic [CW-1:0]              ram_waddr;
	logic [pww_pkg::CHAR_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [CW-1:0]              ram_raddr;
	logic [pww_pkg::CHAR_W-1:0] ram_rdata;

	// Take the width register at any time; the user must write it only while idle (not enforced here).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= pww_pkg::LINE_WIDTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			line_width_q <= line_width;
		end
	end

	// Classify words and keep the current line.
	pww_front #(
		.LINE_CHARS(LINE_CHARS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.char_code    (char_code),
		.advance_fixed(advance_fixed),
		.line_width   (line_width_q),
		.q_full       (q_full),
		.q_empty      (q_empty),
		.q_front      (q_front),
		.back_stat    (back_stat),
		.push         (push),
		.push_cmd     (push_cmd),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata)
	);

	// Decouple classification from line emission.
	pww_cmd_queue #(
		.DEPTH(pww_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (q_pop),
		.front   (q_front),
		.empty   (q_empty),
		.full    (q_full)
	);

	// Character ring: power-of-two depth so pointers wrap for free.
	pww_ram #(
		.WIDTH(pww_pkg::CHAR_W),
		.DEPTH(RING)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Stream out queued lines.
	pww_back #(
		.LINE_CHARS(LINE_CHARS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_front     (q_front),
		.q_pop       (q_pop),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.back_stat   (back_stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.last_of_line(last_of_line)
	);

endmodule

[sim/pixel_width_word_wrapper_tb.sv]
// Self-checking testbench for the pixel width word wrapper.
// Needs pww_pkg and pixel_width_word_wrapper; runs a directed table, then random text.
// An internal line model predicts every output word.
module pixel_width_word_wrapper_tb;
	import pww_pkg::*;

	localparam int LINE_CHARS  = LINE_CHARS_DEF;
	localparam int CYCLE_LIMIT = 8000000;
	// Cycles allowed after the last expected word for the pipeline to go quiet.
	localparam int SETTLE      = 12;

	// One output word as the checker sees it.
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} line_word_t;

	// One row of the directed table. When typed is set, the row carries the
	// word count it must cause and the code of its final word.
	typedef struct packed {
		logic              m;
		logic [CHAR_W-1:0] c;
		logic [ADV_W-1:0]  a;
		logic              typed;
		logic [6:0]        n;
		logic [CHAR_W-1:0] tail;
	} text_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               mode = MODE_CHAR;
	logic [CHAR_W-1:0]  char_code = '0;
	logic [ADV_W-1:0]   advance_fixed = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [CHAR_W-1:0]  out_char;
	logic               last_of_line;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [WIDTH_W-1:0] line_width = LINE_WIDTH_RST;

	// Words the line model has produced and the block has not yet sent.
	line_word_t expected_words[$];

	// Line model state: stored characters, pen position and last word end.
	logic [CHAR_W-1:0] line_buf [LINE_CHARS];
	int unsigned       buf_len = 0;
	int unsigned       pen_x = 0;
	int unsigned       cut_idx = 0;
	int unsigned       cut_x = 0;
	bit                cut_ok = 1'b0;
	int unsigned       wrap_width = LINE_WIDTH_RST;

	int  mismatches = 0;
	int  cycle_count = 0;
	// Set for a stretch with no gaps and no stalls.
	bit  calm = 1'b0;
	int  stall_left = 0;

	// Directed table, default width of 640 pixels after reset.
	text_row_t text_rows [16] = '{
		// newline on an empty line: a lone newline
		'{MODE_CHAR,  CH_NEWLINE,    16'h0000, 1'b1, 7'd1, CH_NEWLINE},
		// flush on an empty line, with every payload bit set: nothing
		'{MODE_FLUSH, 21'h1FFFFF,    16'hFFFF, 1'b1, 7'd0, 21'd0},
		// leading space: dropped
		'{MODE_CHAR,  CH_SPACE,      16'h0280, 1'b1, 7'd0, 21'd0},
		// widest glyph (1023 px) on an empty line: no break, starts the line
		'{MODE_CHAR,  21'd65,        16'hFFFF, 1'b1, 7'd0, 21'd0},
		// next glyph passes the width with no word end: whole line plus newline
		'{MODE_CHAR,  21'd66,        16'h0040, 1'b1, 7'd2, CH_NEWLINE},
		// largest code, fraction bits only (zero pixels)
		'{MODE_CHAR,  21'h1FFFFF,    16'h003F, 1'b1, 7'd0, 21'd0},
		// code zero
		'{MODE_CHAR,  21'd0,         16'h0040, 1'b1, 7'd0, 21'd0},
		// space records a word end
		'{MODE_CHAR,  CH_SPACE,      16'h0140, 1'b0, 7'd0, 21'd0},
		'{MODE_CHAR,  21'd67,        16'h0140, 1'b0, 7'd0, 21'd0},
		// fills the line to just under the width
		'{MODE_CHAR,  21'd68,        16'h9C40, 1'b0, 7'd0, 21'd0},
		// width break at the word end, the rest of the line kept
		'{MODE_CHAR,  21'd69,        16'h0100, 1'b0, 7'd0, 21'd0},
		// two spaces in a row
		'{MODE_CHAR,  CH_SPACE,      16'h0040, 1'b0, 7'd0, 21'd0},
		'{MODE_CHAR,  CH_SPACE,      16'h0040, 1'b0, 7'd0, 21'd0},
		'{MODE_CHAR,  21'd70,        16'h0FC0, 1'b0, 7'd0, 21'd0},
		// flush a non-empty line
		'{MODE_FLUSH, 21'd0,         16'h0000, 1'b0, 7'd0, 21'd0},
		// newline right after a flush: a lone newline again
		'{MODE_CHAR,  CH_NEWLINE,    16'h1234, 1'b1, 7'd1, CH_NEWLINE}
	};

	pixel_width_word_wrapper #(
		.LINE_CHARS(LINE_CHARS)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.char_code     (char_code),
		.advance_fixed (advance_fixed),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_char      (out_char),
		.last_of_line  (last_of_line),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.line_width    (line_width)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop: a hung handshake must not run forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d words still expected", $time, expected_words.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Idle length: mostly short, some medium, a few long.
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			pick_idle = $urandom_range(1, 3);
		else if (r < 95)
			pick_idle = $urandom_range(4, 12);
		else
			pick_idle = $urandom_range(20, 60);
	endfunction

	function automatic int unsigned sat_px(input int unsigned v);
		sat_px = (v > PIX_MAX) ? PIX_MAX : v;
	endfunction

	// Line model: apply one accepted word and queue the words it must cause.
	// dropped marks a word the block has nothing to do with.
	task automatic wrap_predict(input logic m, input logic [CHAR_W-1:0] c,
			input logic [ADV_W-1:0] a, output bit dropped, output int produced,
			output logic [CHAR_W-1:0] tail);
		int unsigned adv_px;
		int unsigned keep;
		int unsigned i;
		int          base;
		bit          cut;
		base = expected_words.size();
		adv_px = a >> FRAC_BITS;
		if (m == MODE_FLUSH) begin
			dropped = (buf_len == 0);
			if (buf_len != 0) begin
				for (i = 0; i < buf_len; i++)
					expected_words.push_back({line_buf[i], i + 1 == buf_len});
				buf_len = 0;
				pen_x = 0;
				cut_idx = 0;
				cut_x = 0;
				cut_ok = 1'b0;
			end
		end else begin
			// a space on an empty line can never break, so it is simply dropped
			dropped = (c == CH_SPACE) && (buf_len == 0);
			cut = (c == CH_NEWLINE) || (buf_len >= LINE_CHARS) ||
				(buf_len > 0 && pen_x + adv_px > wrap_width);
			if (cut) begin
				if (c == CH_NEWLINE || !cut_ok) begin
					// emit the whole line
					for (i = 0; i < buf_len; i++)
						expected_words.push_back({line_buf[i], 1'b0});
					expected_words.push_back({CH_NEWLINE, 1'b1});
					buf_len = 0;
					pen_x = 0;
				end else begin
					// emit up to the word end, drop the space, keep the tail
					keep = cut_idx + 2;
					if (keep > buf_len)
						keep = buf_len;
					for (i = 0; i <= cut_idx; i++)
						expected_words.push_back({line_buf[i], 1'b0});
					expected_words.push_back({CH_NEWLINE, 1'b1});
					for (i = keep; i < buf_len; i++)
						line_buf[i - keep] = line_buf[i];
					buf_len = buf_len - keep;
					pen_x = (pen_x > cut_x) ? pen_x - cut_x : 0;
				end
				cut_idx = 0;
				cut_x = 0;
				cut_ok = 1'b0;
			end
			if (c == CH_SPACE && buf_len > 0) begin
				cut_idx = buf_len - 1;
				cut_x = sat_px(pen_x + adv_px);
				cut_ok = 1'b1;
			end
			if (c != CH_NEWLINE && !(buf_len == 0 && c == CH_SPACE) &&
					buf_len < LINE_CHARS) begin
				line_buf[buf_len] = c;
				buf_len = buf_len + 1;
				pen_x = sat_px(pen_x + adv_px);
			end
		end
		produced = expected_words.size() - base;
		tail = (produced > 0) ? expected_words[$].ch : '0;
	endtask

	// Present one input word, hold it until accepted, then maybe idle.
	// Valid stays high when the next word follows at once.
	task automatic send_word(input logic m, input logic [CHAR_W-1:0] c,
			input logic [ADV_W-1:0] a, output bit dropped, output int produced,
			output logic [CHAR_W-1:0] tail);
		int gap;
		in_valid <= 1'b1;
		mode <= m;
		char_code <= c;
		advance_fixed <= a;
		do @(posedge clk); while (in_stall);
		wrap_predict(m, c, a, dropped, produced, tail);
		gap = calm ? 0 : ($urandom_range(0, 1) ? pick_idle() : 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drain every pending line, let the block settle, then write the width.
	task automatic set_width(input logic [WIDTH_W-1:0] w);
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		line_width <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		wrap_width = w;
	endtask

	// Random text: mostly words of random glyphs ended by spaces, newlines or
	// flushes, with some raw noise words. Dropped words do not count.
	task automatic run_text(input int want);
		int                done;
		int                len;
		int                r;
		int                k;
		int                produced;
		bit                dropped;
		logic [CHAR_W-1:0] tail;
		logic [CHAR_W-1:0] c;
		logic [ADV_W-1:0]  a;
		done = 0;
		while (done < want) begin
			calm = ($urandom_range(0, 9) == 0);
			r = $urandom_range(0, 99);
			if (r < 80) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
					: $urandom_range(1, 10);
				for (k = 0; k < len; k++) begin
					r = $urandom_range(0, 99);
					if (r < 85)
						c = CHAR_W'($urandom_range(33, 126));
					else if (r < 95)
						c = CHAR_W'($urandom());
					else
						c = '0;
					r = $urandom_range(0, 99);
					if (r < 70)
						a = ADV_W'(($urandom_range(3, 16) << FRAC_BITS) + $urandom_range(0, 63));
					else if (r < 90)
						a = ADV_W'($urandom());
					else
						a = '0;
					send_word(MODE_CHAR, c, a, dropped, produced, tail);
					done += dropped ? 0 : 1;
				end
				// end the word
				r = $urandom_range(0, 99);
				a = ADV_W'(($urandom_range(2, 8) << FRAC_BITS) + $urandom_range(0, 63));
				if (r < 70) begin
					send_word(MODE_CHAR, CH_SPACE, a, dropped, produced, tail);
					done += dropped ? 0 : 1;
					if (r >= 60) begin
						send_word(MODE_CHAR, CH_SPACE, a, dropped, produced, tail);
						done += dropped ? 0 : 1;
					end
				end else if (r < 82) begin
					send_word(MODE_CHAR, CH_NEWLINE, a, dropped, produced, tail);
					done += dropped ? 0 : 1;
				end else if (r < 88) begin
					send_word(MODE_FLUSH, CHAR_W'($urandom()), a, dropped, produced, tail);
					done += dropped ? 0 : 1;
				end
			end else begin
				send_word(logic'($urandom_range(0, 1)), CHAR_W'($urandom()),
					ADV_W'($urandom()), dropped, produced, tail);
				done += dropped ? 0 : 1;
			end
		end
		calm = 1'b0;
	endtask

	// Output side: check each accepted word against the oldest expectation,
	// then pick the stall level for the next cycles.
	always @(posedge clk) begin : line_out
		line_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: expected no word, got out_char %h last_of_line %b",
						$time, out_char, last_of_line);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (out_char !== want.ch) begin
						$display("%0t: out_char expected %h, got %h", $time, want.ch, out_char);
						mismatches++;
					end
					if (last_of_line !== want.last) begin
						$display("%0t: last_of_line expected %b, got %b",
							$time, want.last, last_of_line);
						mismatches++;
					end
				end
			end
			// hold the current stall level until its run ends, then draw a new one
			if (calm) begin
				out_stall <= 1'b0;
				stall_left <= 0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
			end else begin
				out_stall <= ($urandom_range(0, 2) == 0);
				stall_left <= pick_idle();
			end
		end
	end

	initial begin : stimulus
		int                k;
		int                produced;
		bit                dropped;
		logic [CHAR_W-1:0] tail;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at the reset width. Typed rows also confirm the line
		// model against values read straight off the rules.
		for (k = 0; k < 16; k++) begin
			send_word(text_rows[k].m, text_rows[k].c, text_rows[k].a, dropped, produced, tail);
			if (text_rows[k].typed && (produced != text_rows[k].n ||
					(produced > 0 && tail !== text_rows[k].tail))) begin
				$display("%0t: row %0d expected %0d words ending %h, got %0d ending %h",
					$time, k, text_rows[k].n, text_rows[k].tail, produced, tail);
				mismatches++;
			end
		end

		// Random text over several widths, the extremes among them.
		set_width('0);
		run_text(40);
		set_width('1);
		run_text(110);
		set_width(WIDTH_W'($urandom_range(40, 400)));
		run_text(100);
		set_width(LINE_WIDTH_RST);
		run_text(100);

		// Drain, give the pipeline time to go quiet, then report.
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[pixel_width_word_wrapper.f]
+incdir+rtl/core
rtl/core/pww_pkg.sv
rtl/core/pww_ram.sv
rtl/core/pww_cmd_queue.sv
rtl/core/pww_front.sv
rtl/core/pww_back.sv
rtl/core/pixel_width_word_wrapper.sv
sim/pixel_width_word_wrapper_tb.sv
